FILE: hw/rtl/nsc_pkg.sv
// Shared types, codes and helper functions for the nearest-neighbour scaler.
// Used by nsc_dp, nsc_ctrl and the top level; it depends on nothing else.
package nsc_pkg;

    localparam int unsigned DIM_W      = 13;
    localparam int unsigned PITCH_W    = 16;
    localparam int unsigned FMT_W      = 2;
    localparam int unsigned PAL_ENT_W  = 9;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FMT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL_ENTRIES = 3'd6;

    localparam logic [1:0] FN_ADDR    = 2'd0;
    localparam logic [1:0] FN_PIXEL   = 2'd1;
    localparam logic [1:0] FN_PALETTE = 2'd2;

    localparam logic [FMT_W-1:0] FMT_RGB565   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_XRGB8888 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_INDEXED  = 2'd2;

    localparam logic KIND_ADDR  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // Channel widening multiplies by 255 and by a rounded-up reciprocal of 31 or 63, which
    // gives the exact floored quotient for every 5-bit and 6-bit channel value.
    localparam int unsigned RECIP_SHIFT = 20;
    localparam logic [28:0] WIDEN5_MULT = 29'(255 * ((1 << RECIP_SHIFT) / 31 + 1));
    localparam logic [28:0] WIDEN6_MULT = 29'(255 * ((1 << RECIP_SHIFT) / 63 + 1));

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] raw_pixel;
        logic [7:0]  palette_slot;
        logic [23:0] palette_color;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [27:0] read_address;
        logic [23:0] target_index;
        logic [31:0] color;
        logic        frame_last;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AWRAP,
        S_XMUL,
        S_XSTART,
        S_XWAIT,
        S_YMUL,
        S_YSTART,
        S_YWAIT,
        S_AMUL,
        S_AOUT,
        S_PTOTAL,
        S_POUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic pal_write;
        logic wrap_pos;
        logic mul_x;
        logic mul_y;
        logic div_start;
        logic div_sel_y;
        logic store_col;
        logic store_row;
        logic mul_addr;
        logic load_addr;
        logic mul_total;
        logic load_pix;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [28:0] q;
        q = 29'(v) * WIDEN5_MULT;
        return q[RECIP_SHIFT+7:RECIP_SHIFT];
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [28:0] q;
        q = 29'(v) * WIDEN6_MULT;
        return q[RECIP_SHIFT+7:RECIP_SHIFT];
    endfunction

endpackage

FILE: hw/rtl/nsc_div.sv
// Iterative restoring divider giving one quotient bit per cycle.
// Depends on nothing else; instantiated by the scaler datapath.
module nsc_div #(
    parameter int unsigned CW = 12,
    parameter int unsigned DW = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CW+DW-1:0] i_dividend,
    input  logic [DW-1:0]    i_divisor,
    output logic [CW-1:0]    o_quotient,
    output logic             o_busy,
    output logic             o_done
);

    localparam int unsigned CNT_W = $clog2(CW);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CW - 1);

    logic [DW-1:0]    r_rem;
    logic [CW-1:0]    r_low;
    logic [DW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DW:0]      trial;
    logic             fits;
    logic [DW:0]      diff;

    assign trial = {r_rem, r_low[CW-1]};
    assign fits  = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[CW+DW-1:CW];
            r_low <= i_dividend[CW-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
            r_low <= {r_low[CW-2:0], fits};
        end
    end

    assign o_quotient = r_low;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

FILE: hw/rtl/nsc_dp.sv
// Datapath of the scaler: configuration registers, raster position, palette memory,
// multiply stages, pixel conversion and the output register. Uses nsc_pkg and nsc_div.
module nsc_dp #(
    parameter int unsigned MAX_DIM       = 4096,
    parameter int unsigned PALETTE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [nsc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nsc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  nsc_pkg::t_in                        i_in_data,
    input  logic                                i_out_ready,
    input  nsc_pkg::t_cmd                       i_cmd,
    output nsc_pkg::t_sts                       o_sts,
    output logic                                o_out_valid,
    output nsc_pkg::t_out                       o_out_data
);

    localparam int unsigned CW  = $clog2(MAX_DIM);
    localparam int unsigned DW  = $clog2(MAX_DIM + 1);
    localparam int unsigned PW  = $clog2(PALETTE_DEPTH);
    localparam int unsigned PCW = 2 * CW;
    localparam int unsigned TW  = 2 * DW;
    localparam int unsigned AW  = CW + nsc_pkg::PITCH_W;

    function automatic logic [DW-1:0] clamp_dim(input logic [nsc_pkg::DIM_W-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end else if (32'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end
        return DW'(v);
    endfunction

    logic [nsc_pkg::DIM_W-1:0]     r_src_w;
    logic [nsc_pkg::DIM_W-1:0]     r_src_h;
    logic [nsc_pkg::DIM_W-1:0]     r_tgt_w;
    logic [nsc_pkg::DIM_W-1:0]     r_tgt_h;
    logic [nsc_pkg::PITCH_W-1:0]   r_pitch;
    logic [nsc_pkg::FMT_W-1:0]     r_fmt;
    logic [nsc_pkg::PAL_ENT_W-1:0] r_pal_entries;

    logic [CW-1:0]    r_ax;
    logic [CW-1:0]    r_ay;
    logic [PCW-1:0]   r_pc;
    logic [31:0]      r_raw;
    logic [CW+DW-1:0] r_prod;
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    r_row;
    logic [AW-1:0]    r_addr_prod;
    logic [CW+DW-1:0] r_tmul;
    logic [TW-1:0]    r_total;
    logic [23:0]      r_pal_q;
    logic [23:0]      r_palette [PALETTE_DEPTH];
    logic             r_out_valid;
    nsc_pkg::t_out    r_out;
    nsc_pkg::t_out    n_out;

    logic [DW-1:0]    sw, sh, tw, th;
    logic [DW-1:0]    ax_e, ay_e, ay_inc, ax_inc, wrap_y_e;
    logic [CW-1:0]    wrap_x, wrap_y, adv_x, adv_y;
    logic             addr_last;
    logic [PCW-1:0]   pc_cur, pc_next;
    logic             pix_last;
    logic [CW+2:0]    col_bytes;
    logic [AW:0]      addr_sum;
    logic [CW+DW:0]   tidx_sum;
    logic             slot_ok, idx_ok;
    logic [23:0]      rgb;
    logic [CW-1:0]    quotient;
    logic             div_busy, div_done;

    assign sw = clamp_dim(r_src_w);
    assign sh = clamp_dim(r_src_h);
    assign tw = clamp_dim(r_tgt_w);
    assign th = clamp_dim(r_tgt_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w       <= nsc_pkg::DIM_W'(256);
            r_src_h       <= nsc_pkg::DIM_W'(240);
            r_tgt_w       <= nsc_pkg::DIM_W'(256);
            r_tgt_h       <= nsc_pkg::DIM_W'(240);
            r_pitch       <= nsc_pkg::PITCH_W'(512);
            r_fmt         <= nsc_pkg::FMT_RGB565;
            r_pal_entries <= nsc_pkg::PAL_ENT_W'(256);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nsc_pkg::CFG_SRC_WIDTH:   r_src_w       <= i_cfg_data[nsc_pkg::DIM_W-1:0];
                nsc_pkg::CFG_SRC_HEIGHT:  r_src_h       <= i_cfg_data[nsc_pkg::DIM_W-1:0];
                nsc_pkg::CFG_TGT_WIDTH:   r_tgt_w       <= i_cfg_data[nsc_pkg::DIM_W-1:0];
                nsc_pkg::CFG_TGT_HEIGHT:  r_tgt_h       <= i_cfg_data[nsc_pkg::DIM_W-1:0];
                nsc_pkg::CFG_ROW_PITCH:   r_pitch       <= i_cfg_data;
                nsc_pkg::CFG_PIXEL_FMT:   r_fmt         <= i_cfg_data[nsc_pkg::FMT_W-1:0];
                nsc_pkg::CFG_PAL_ENTRIES: r_pal_entries <= i_cfg_data[nsc_pkg::PAL_ENT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        ax_e     = DW'(r_ax);
        ay_e     = DW'(r_ay);
        ay_inc   = ay_e + 1'b1;
        ax_inc   = ax_e + 1'b1;
        wrap_x   = r_ax;
        wrap_y_e = ay_e;
        if (ax_e >= tw) begin
            wrap_x   = '0;
            wrap_y_e = ay_inc;
        end
        wrap_y = wrap_y_e[CW-1:0];
        if (wrap_y_e >= th) begin
            wrap_x = '0;
            wrap_y = '0;
        end
        adv_y = r_ay;
        if (ax_inc >= tw) begin
            adv_x = '0;
            adv_y = (ay_inc >= th) ? '0 : ay_inc[CW-1:0];
        end else begin
            adv_x = ax_inc[CW-1:0];
        end
        addr_last = (ax_e == tw - 1'b1) && (ay_e == th - 1'b1);
    end

    always_comb begin
        pc_cur   = (TW'(r_pc) >= r_total) ? '0 : r_pc;
        pix_last = TW'(pc_cur) == r_total - 1'b1;
        pc_next  = pix_last ? '0 : pc_cur + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_pc <= '0;
        end else begin
            if (i_cmd.wrap_pos) begin
                r_ax <= wrap_x;
                r_ay <= wrap_y;
            end else if (i_cmd.load_addr) begin
                r_ax <= adv_x;
                r_ay <= adv_y;
            end
            if (i_cmd.load_pix) begin
                r_pc <= pc_next;
            end
        end
    end

    nsc_div #(
        .CW (CW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (i_cmd.div_sel_y ? th : tw),
        .o_quotient (quotient),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw <= i_in_data.raw_pixel;
        end
        if (i_cmd.mul_x) begin
            r_prod <= (CW+DW)'(r_ax) * (CW+DW)'(sw);
        end else if (i_cmd.mul_y) begin
            r_prod <= (CW+DW)'(r_ay) * (CW+DW)'(sh);
        end
        if (i_cmd.store_col) begin
            r_col <= quotient;
        end
        if (i_cmd.store_row) begin
            r_row <= quotient;
        end
        if (i_cmd.mul_addr) begin
            r_addr_prod <= AW'(r_row) * AW'(r_pitch);
            r_tmul      <= (CW+DW)'(r_ay) * (CW+DW)'(tw);
        end
        if (i_cmd.mul_total) begin
            r_total <= TW'(tw) * TW'(th);
        end
    end

    assign slot_ok = {1'b0, i_in_data.palette_slot} < 9'(PALETTE_DEPTH);
    assign idx_ok  = ({1'b0, r_raw[7:0]} < r_pal_entries) &&
                     ({1'b0, r_raw[7:0]} < 9'(PALETTE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_write && slot_ok) begin
            r_palette[i_in_data.palette_slot[PW-1:0]] <= i_in_data.palette_color;
        end
        r_pal_q <= r_palette[r_raw[PW-1:0]];
    end

    always_comb begin
        unique case (r_fmt)
            nsc_pkg::FMT_RGB565: begin
                col_bytes = {1'b0, r_col, 2'b0} >> 1;
                rgb = {nsc_pkg::widen5(r_raw[15:11]), nsc_pkg::widen6(r_raw[10:5]),
                       nsc_pkg::widen5(r_raw[4:0])};
            end
            nsc_pkg::FMT_INDEXED: begin
                col_bytes = (CW+3)'(r_col);
                rgb = idx_ok ? r_pal_q : 24'h0;
            end
            default: begin
                col_bytes = {1'b0, r_col, 2'b0};
                rgb = r_raw[23:0];
            end
        endcase
        addr_sum = (AW+1)'(r_addr_prod) + (AW+1)'(col_bytes);
        tidx_sum = (CW+DW+1)'(r_tmul) + (CW+DW+1)'(r_ax);

        n_out = '0;
        if (i_cmd.load_pix) begin
            n_out.kind         = nsc_pkg::KIND_PIXEL;
            n_out.target_index = 24'(pc_cur);
            n_out.color        = {nsc_pkg::ALPHA_OPAQUE, rgb};
            n_out.frame_last   = pix_last;
        end else begin
            n_out.kind         = nsc_pkg::KIND_ADDR;
            n_out.read_address = 28'(addr_sum);
            n_out.target_index = 24'(tidx_sum);
            n_out.frame_last   = addr_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_addr || i_cmd.load_pix) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_addr || i_cmd.load_pix) begin
            r_out <= n_out;
        end
    end

    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

FILE: hw/rtl/nsc_ctrl.sv
// Controller state machine of the scaler: sequences address and pixel transactions.
// Uses nsc_pkg for its state type and the command and status structs.
module nsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_func,
    input  nsc_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output nsc_pkg::t_cmd o_cmd
);

    nsc_pkg::t_state r_state;
    nsc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            nsc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_func)
                        nsc_pkg::FN_ADDR:    n_state = nsc_pkg::S_AWRAP;
                        nsc_pkg::FN_PIXEL:   n_state = nsc_pkg::S_PTOTAL;
                        nsc_pkg::FN_PALETTE: o_cmd.pal_write = 1'b1;
                        default: begin
                        end
                    endcase
                end
            end
            nsc_pkg::S_AWRAP: begin
                o_cmd.wrap_pos = 1'b1;
                n_state = nsc_pkg::S_XMUL;
            end
            nsc_pkg::S_XMUL: begin
                o_cmd.mul_x = 1'b1;
                n_state = nsc_pkg::S_XSTART;
            end
            nsc_pkg::S_XSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = nsc_pkg::S_XWAIT;
            end
            nsc_pkg::S_XWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.store_col = 1'b1;
                    n_state = nsc_pkg::S_YMUL;
                end
            end
            nsc_pkg::S_YMUL: begin
                o_cmd.mul_y = 1'b1;
                n_state = nsc_pkg::S_YSTART;
            end
            nsc_pkg::S_YSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                n_state = nsc_pkg::S_YWAIT;
            end
            nsc_pkg::S_YWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.store_row = 1'b1;
                    n_state = nsc_pkg::S_AMUL;
                end
            end
            nsc_pkg::S_AMUL: begin
                o_cmd.mul_addr = 1'b1;
                n_state = nsc_pkg::S_AOUT;
            end
            nsc_pkg::S_AOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_addr = 1'b1;
                    n_state = nsc_pkg::S_IDLE;
                end
            end
            nsc_pkg::S_PTOTAL: begin
                o_cmd.mul_total = 1'b1;
                n_state = nsc_pkg::S_POUT;
            end
            nsc_pkg::S_POUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_pix = 1'b1;
                    n_state = nsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nsc_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_addr || o_cmd.load_pix) |-> i_sts.out_free)
        else $error("Result loaded while the output register is still occupied.");

    a_div_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("Divider started while a division is in progress.");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == nsc_pkg::S_XWAIT || r_state == nsc_pkg::S_YWAIT))
        else $error("Divider finished outside a wait state.");

    a_work_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready &&
         (i_func == nsc_pkg::FN_ADDR || i_func == nsc_pkg::FN_PIXEL))
        |=> r_state != nsc_pkg::S_IDLE)
        else $error("Address or pixel transaction accepted without starting work.");
`endif

endmodule

FILE: hw/rtl/nearest_scaler_pixel_convert.sv
// Top level of the nearest-neighbour scaler and pixel converter.
// Joins nsc_ctrl and nsc_dp; uses nsc_pkg for payload, command and status types.
//
// The block walks the target raster and, for each address transaction, returns the byte
// address of the nearest source pixel; for each pixel transaction it returns the fetched
// pixel converted to opaque XRGB8888 with its target index and an end-of-frame flag. A
// palette write transaction loads one colour and gives no result. An address transaction
// wraps the raster position, then multiplies and divides for the source column, then for
// the source row, then forms the address before its result enters the output register;
// the shared divider produces one quotient bit per cycle, first for the source column
// and then for the source row. A pixel transaction computes the target pixel total before
// its result enters the output register. A result still waiting in the output register
// holds back the next result until it is taken. The next input transaction is accepted
// as soon as the previous result has entered the output register, even while that result
// waits to be taken. Palette entries hold no defined value until written.
module nearest_scaler_pixel_convert #(
    parameter int unsigned MAX_DIM       = 4096,
    parameter int unsigned PALETTE_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  nsc_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output nsc_pkg::t_out                  o_out_data
);

    nsc_pkg::t_cmd cmd;
    nsc_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    nsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    nsc_dp #(
        .MAX_DIM       (MAX_DIM),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
